/* rtl/core/u16d_pkg.sv */
// Shared types, constants and status codes for the UTF-16 stream decoder.
package u16d_pkg;

  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;
  localparam int STAT_W = 3;
  localparam int MODE_W = 2;

  // byte order modes
  localparam logic [MODE_W-1:0] MODE_DETECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIG    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LITTLE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_CODE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNPAIRED = 3'd2;
  localparam logic [STAT_W-1:0] ST_LONE_LOW = 3'd3;
  localparam logic [STAT_W-1:0] ST_CONFLICT = 3'd4;
  localparam logic [STAT_W-1:0] ST_SKIPPED  = 3'd5;

  // what the front decided about a unit
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_MARK     = 2'd1;
  localparam logic [1:0] KIND_CONFLICT = 2'd2;

  localparam logic [UNIT_W-1:0] BOM_BE    = 16'hFEFF;
  localparam logic [UNIT_W-1:0] BOM_LE    = 16'hFFFE;
  localparam logic [UNIT_W-1:0] SURR_MASK = 16'hFC00;
  localparam logic [UNIT_W-1:0] SURR_HIGH = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_LOW  = 16'hDC00;
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [UNIT_W-1:0] value;   // unit in native order
    logic [1:0]        kind;
    logic              is_high;
    logic              is_low;
    logic              last;
  } u16d_item_t;

endpackage

/* rtl/core/u16d_front.sv */
// Front end: string start tracking, byte order choice and unit classification.
module u16d_front
  import u16d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [UNIT_W-1:0] in_unit_bytes,
  input  logic              in_last_unit,
  input  logic              q_ready,
  output logic              q_push,
  output u16d_item_t        q_item
);

  logic start_r, start_nxt;
  logic swap_r, swap_nxt;
  logic start_swap;
  logic swap_eff;
  logic [1:0] start_kind;
  logic [UNIT_W-1:0] native;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    start_swap = 1'b0;
    start_kind = KIND_DATA;
    case (mode)
      MODE_BIG: begin
        if (in_unit_bytes == BOM_BE) begin
          start_kind = KIND_MARK;
        end else if (in_unit_bytes == BOM_LE) begin
          start_kind = KIND_CONFLICT;
        end
      end
      MODE_LITTLE: begin
        start_swap = 1'b1;
        if (in_unit_bytes == BOM_LE) begin
          start_kind = KIND_MARK;
        end else if (in_unit_bytes == BOM_BE) begin
          start_kind = KIND_CONFLICT;
        end
      end
      default: begin
        // detect: unmarked strings default to big-endian
        if (in_unit_bytes == BOM_BE) begin
          start_kind = KIND_MARK;
        end else if (in_unit_bytes == BOM_LE) begin
          start_kind = KIND_MARK;
          start_swap = 1'b1;
        end
      end
    endcase
  end

  assign swap_eff = start_r ? start_swap : swap_r;
  assign native   = swap_eff ? {in_unit_bytes[7:0], in_unit_bytes[15:8]} : in_unit_bytes;

  always_comb begin
    q_item.value   = native;
    q_item.kind    = start_r ? start_kind : KIND_DATA;
    q_item.is_high = (native & SURR_MASK) == SURR_HIGH;
    q_item.is_low  = (native & SURR_MASK) == SURR_LOW;
    q_item.last    = in_last_unit;
  end

  always_comb begin
    start_nxt = start_r;
    swap_nxt  = swap_r;
    if (q_push) begin
      if (in_last_unit) begin
        start_nxt = 1'b1;
        swap_nxt  = 1'b0;
      end else if (start_r) begin
        start_nxt = 1'b0;
        swap_nxt  = start_swap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      swap_r  <= 1'b0;
    end else begin
      start_r <= start_nxt;
      swap_r  <= swap_nxt;
    end
  end

endmodule

/* rtl/core/u16d_queue.sv */
// Two-entry queue between the front end and the decode back end.
module u16d_queue
  import u16d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u16d_item_t push_item,
  output logic       push_ready,
  input  logic       pop,
  output logic       pop_valid,
  output u16d_item_t pop_item
);

  u16d_item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/core/u16d_back.sv */
// Back end: surrogate pairing, error tracking and the output register.
module u16d_back
  import u16d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  u16d_item_t        q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   out_scalar,
  output logic [STAT_W-1:0] out_status,
  output logic              out_last_result
);

  logic failed_r, failed_nxt;
  logic pend_r, pend_nxt;
  logic [9:0] held_r, held_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic last_r;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    failed_nxt = failed_r;
    pend_nxt   = pend_r;
    held_nxt   = held_r;
    cp_nxt     = '0;
    status_nxt = ST_NOTHING;
    if (failed_r) begin
      status_nxt = ST_SKIPPED;
    end else begin
      case (q_item.kind)
        KIND_CONFLICT: begin
          status_nxt = ST_CONFLICT;
          failed_nxt = 1'b1;
        end
        KIND_MARK: begin
          status_nxt = ST_NOTHING;
        end
        default: begin
          if (pend_r) begin
            pend_nxt = 1'b0;
            held_nxt = '0;
            if (q_item.is_low) begin
              cp_nxt     = CP_W'({held_r, q_item.value[9:0]}) + SUPP_BASE;
              status_nxt = ST_CODE;
            end else begin
              status_nxt = ST_UNPAIRED;
              failed_nxt = 1'b1;
            end
          end else if (q_item.is_high) begin
            held_nxt   = q_item.value[9:0];
            pend_nxt   = 1'b1;
            status_nxt = q_item.last ? ST_UNPAIRED : ST_NOTHING;
          end else if (q_item.is_low) begin
            status_nxt = ST_LONE_LOW;
            failed_nxt = 1'b1;
          end else begin
            cp_nxt     = CP_W'(q_item.value);
            status_nxt = ST_CODE;
          end
        end
      endcase
    end
    // end of string: back to a clean state
    if (q_item.last) begin
      failed_nxt = 1'b0;
      pend_nxt   = 1'b0;
      held_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r    <= 1'b0;
      pend_r      <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        failed_r <= failed_nxt;
        pend_r   <= pend_nxt;
        held_r   <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cp_r     <= cp_nxt;
      status_r <= status_nxt;
      last_r   <= q_item.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scalar      = cp_r;
  assign out_status      = status_r;
  assign out_last_result = last_r;

  // held bits are only nonzero while a high surrogate waits
  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> held_r == '0)
    else $error("held surrogate bits without pending high");

  // an error ends any pairing in progress
  a_failed_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> !pend_r)
    else $error("failed string still holds a high surrogate");

  a_skip_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && failed_r |=> out_valid_r && status_r == ST_SKIPPED)
    else $error("unit after an error not reported as skipped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !q_pop)
    else $error("pending result overwritten");

endmodule

/* rtl/core/utf16_stream_decoder_core.sv */
// UTF-16 stream decoder top level: register port, front end, queue, back end.
// A unit's result passes through the queue entry, written when the unit is accepted,
// and then the back end's output register, loaded when the back end pops it.
// Throughput: one unit per cycle while out_ready holds, the back end decoding
// combinationally; the two-entry queue and output register decouple the two sides.
// Reset (synchronous, active low): mode back to detect, string state cleared.
module utf16_stream_decoder_core
  import u16d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [UNIT_W-1:0] in_unit_bytes,
  input  logic              in_last_unit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   out_scalar,
  output logic [STAT_W-1:0] out_status,
  output logic              out_last_result
);

  logic [MODE_W-1:0] mode_r;
  logic       q_ready, q_push, q_pop, q_valid;
  u16d_item_t push_item, pop_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-MODE_W){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DETECT;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mode_r <= pwdata[MODE_W-1:0];
    end
  end

  u16d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_unit_bytes (in_unit_bytes),
    .in_last_unit  (in_last_unit),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  u16d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (pop_item)
  );

  u16d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scalar      (out_scalar),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

endmodule
